/* rtl/deficit_weighted_transfer_picker_defines.svh */
// Assertion macros shared by the picker's checker.
// Needs a clk and an rst signal in the scope where a macro is used.
`ifndef DEFICIT_WEIGHTED_TRANSFER_PICKER_DEFINES_SVH
`define DEFICIT_WEIGHTED_TRANSFER_PICKER_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define DWTP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet during reset.
`define DWTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/dwtp_pkg.sv */
// Shared types and constants of the deficit weighted transfer picker.
// No dependencies; used by the checker and every RTL module except dwtp_ram.
package dwtp_pkg;

  localparam int MAX_CANDIDATES = 16;
  localparam int IDX_W          = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
  localparam int CNT_W          = $clog2(MAX_CANDIDATES + 1);

  localparam int RATIO_W  = 17;
  localparam int AGING_W  = 16;
  localparam int WSIZE_W  = 24;
  localparam int FAM_W    = 16;
  localparam int SEQ_W    = 32;
  localparam int PRIO_W   = 8;
  localparam int AGE_W    = 24;
  localparam int BYTES_W  = 24;
  localparam int DEF_W    = 26;
  localparam int TOTAL_W  = BYTES_W + 1;
  localparam int WPROD_W  = RATIO_W + TOTAL_W;
  localparam int APROD_W  = AGING_W + AGE_W;
  localparam int EFF_W    = APROD_W + 1;
  localparam int SUM_W    = DEF_W + 2;
  localparam int CHOSEN_W = 4;

  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 8;
  localparam int USER_W     = 2;
  localparam int ADDR_W     = 4;
  localparam int PDATA_W    = 32;

  localparam logic [RATIO_W-1:0] RATIO_ONE   = RATIO_W'(65536);
  localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(32768);
  localparam logic [AGING_W-1:0] AGING_RESET = '0;
  localparam logic [WSIZE_W-1:0] WSIZE_RESET = WSIZE_W'(65536);
  localparam logic signed [SUM_W-1:0] DEF_MAX = SUM_W'(33554431);
  localparam logic signed [SUM_W-1:0] DEF_MIN = -SUM_W'(33554432);

  // Register indexes (byte address bits [3:2]).
  localparam logic [1:0] REG_STREAM_RATIO = 2'd0;
  localparam logic [1:0] REG_AGING_RATE   = 2'd1;
  localparam logic [1:0] REG_WINDOW_SIZE  = 2'd2;

  typedef enum logic [1:0] {
    ACT_CAND   = 2'd0,
    ACT_BEGIN  = 2'd1,
    ACT_SUBMIT = 2'd2,
    ACT_EMPTY  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WIN,
    S_RD_I,
    S_CAP_I,
    S_SCAN,
    S_EVAL,
    S_DONE,
    S_EMPTY
  } state_t;

  typedef struct packed {
    logic [FAM_W-1:0] family;
    logic [SEQ_W-1:0] seq;
  } cand_key_t;

  typedef struct packed {
    logic              elig;
    logic              kind;
    logic [PRIO_W-1:0] prio;
    logic [AGE_W-1:0]  age;
  } cand_attr_t;

  typedef struct packed {
    logic load_cand;
    logic pick_init;
    logic begin_win;
    logic win_mul;
    logic win_upd;
    logic rd_i;
    logic cap_i;
    logic scan;
    logic eval;
    logic out_load;
    logic out_none;
  } cmd_t;

  typedef struct packed {
    logic j_last;
    logic i_last;
    logic out_free;
  } sts_t;

endpackage

/* rtl/dwtp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dwtp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/dwtp_ctrl.sv */
// Sequencer of the picker: request decode, pick scan order, result handoff.
// Depends on dwtp_pkg.
module dwtp_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [dwtp_pkg::USER_W-1:0] s_tuser,
  input  logic                       s_tlast,
  input  dwtp_pkg::sts_t             sts,
  output dwtp_pkg::cmd_t             cmd
);
  import dwtp_pkg::*;

  state_t  state, state_next;
  action_t act;

  assign act = action_t'(s_tuser);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          case (act)
            ACT_CAND: begin
              cmd.load_cand = 1'b1;
              if (s_tlast) begin
                cmd.pick_init = 1'b1;
                state_next    = S_RD_I;
              end
            end
            ACT_BEGIN:  cmd.begin_win = 1'b1;
            ACT_SUBMIT: begin
              cmd.win_mul = 1'b1;
              state_next  = S_WIN;
            end
            ACT_EMPTY:  state_next = S_EMPTY;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_WIN: begin
        cmd.win_upd = 1'b1;
        state_next  = S_IDLE;
      end
      S_RD_I: begin
        cmd.rd_i   = 1'b1;
        state_next = S_CAP_I;
      end
      S_CAP_I: begin
        cmd.cap_i  = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.j_last) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = sts.i_last ? S_DONE : S_RD_I;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_none = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* rtl/dwtp_dp.sv */
// Datapath of the picker: deficit, candidate store, family-head scan,
// best-candidate tracking and the result register. Depends on dwtp_pkg, dwtp_ram.
module dwtp_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  dwtp_pkg::cmd_t                  cmd,
  output dwtp_pkg::sts_t                  sts,
  input  logic [dwtp_pkg::IN_DATA_W-1:0]  in_data,
  input  logic [dwtp_pkg::RATIO_W-1:0]    stream_ratio,
  input  logic [dwtp_pkg::AGING_W-1:0]    aging_rate,
  input  logic [dwtp_pkg::WSIZE_W-1:0]    window_size,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [dwtp_pkg::OUT_DATA_W-1:0] m_tdata
);
  import dwtp_pkg::*;

  // Input fields
  cand_key_t          in_key;
  cand_attr_t         in_attr;
  logic [BYTES_W-1:0] in_async, in_stream;

  assign in_attr.elig   = in_data[0];
  assign in_attr.kind   = in_data[1];
  assign in_key.family  = in_data[17:2];
  assign in_key.seq     = in_data[49:18];
  assign in_attr.prio   = in_data[57:50];
  assign in_attr.age    = in_data[81:58];
  assign in_async       = in_data[105:82];
  assign in_stream      = in_data[129:106];

  // Deficit and window accounting
  logic signed [DEF_W-1:0] deficit;
  logic                    primary_kind;
  logic [WPROD_W-1:0]      win_prod;
  logic [BYTES_W-1:0]      win_stream;
  logic [RATIO_W-1:0]      ratio_c;
  logic [TOTAL_W-1:0]      total;
  logic signed [SUM_W-1:0] d_sum, d_hi, d_lo, d_clamp;

  assign ratio_c = (stream_ratio > RATIO_ONE) ? RATIO_ONE : stream_ratio;
  assign total   = TOTAL_W'(in_async) + TOTAL_W'(in_stream);

  always_comb begin
    d_sum = SUM_W'(deficit) + SUM_W'(win_prod[WPROD_W-1:16]) - SUM_W'(win_stream);
    if (window_size != '0) begin
      d_hi = SUM_W'(window_size);
      d_lo = -d_hi;
    end else begin
      d_hi = DEF_MAX;
      d_lo = DEF_MIN;
    end
    if (d_sum > d_hi) begin
      d_clamp = d_hi;
    end else if (d_sum < d_lo) begin
      d_clamp = d_lo;
    end else begin
      d_clamp = d_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.win_mul) begin
      win_prod   <= WPROD_W'(ratio_c) * WPROD_W'(total);
      win_stream <= in_stream;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deficit      <= '0;
      primary_kind <= 1'b0;
    end else begin
      if (cmd.win_upd) begin
        deficit <= d_clamp[DEF_W-1:0];
      end
      if (cmd.begin_win) begin
        primary_kind <= (deficit > 0);
      end
    end
  end

  // Candidate store
  logic [CNT_W-1:0] cnt, cnt_m1;
  logic             dropped;
  logic             full;
  logic             we;
  logic [IDX_W-1:0] raddr;
  cand_key_t        rd_key;
  cand_attr_t       rd_attr;

  assign full   = (cnt == CNT_W'(MAX_CANDIDATES));
  assign we     = cmd.load_cand && !full;
  assign cnt_m1 = cnt - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      dropped <= 1'b0;
    end else if (cmd.out_load) begin
      cnt     <= '0;
      dropped <= 1'b0;
    end else if (cmd.load_cand) begin
      if (full) begin
        dropped <= 1'b1;
      end else begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  dwtp_ram #(.WIDTH($bits(cand_key_t)), .DEPTH(MAX_CANDIDATES)) u_key_ram (
    .clk   (clk),
    .we    (we),
    .waddr (cnt[IDX_W-1:0]),
    .wdata (in_key),
    .raddr (raddr),
    .rdata (rd_key)
  );

  dwtp_ram #(.WIDTH($bits(cand_attr_t)), .DEPTH(MAX_CANDIDATES)) u_attr_ram (
    .clk   (clk),
    .we    (we),
    .waddr (cnt[IDX_W-1:0]),
    .wdata (in_attr),
    .raddr (raddr),
    .rdata (rd_attr)
  );

  // Scan: icnt walks the candidates, jcnt walks the rest of the family check
  logic [CNT_W-1:0]   icnt, jcnt, jcnt_p1;
  cand_key_t          cur_key;
  cand_attr_t         cur_attr;
  logic               head;
  logic [APROD_W-1:0] age_prod;
  logic [EFF_W-1:0]   cur_eff;

  assign jcnt_p1 = jcnt + CNT_W'(1);

  // capture cycle reads entry 0 for the first family compare
  always_comb begin
    if (cmd.scan) begin
      raddr = jcnt_p1[IDX_W-1:0];
    end else if (cmd.rd_i) begin
      raddr = icnt[IDX_W-1:0];
    end else begin
      raddr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pick_init) begin
      icnt <= '0;
    end else if (cmd.eval) begin
      icnt <= icnt + CNT_W'(1);
    end
    if (cmd.cap_i) begin
      cur_key  <= rd_key;
      cur_attr <= rd_attr;
      head     <= 1'b1;
      jcnt     <= '0;
    end else if (cmd.scan) begin
      jcnt <= jcnt_p1;
      if (jcnt != icnt && rd_key.family == cur_key.family && rd_key.seq < cur_key.seq) begin
        head <= 1'b0;
      end
    end
    if (cmd.scan) begin
      age_prod <= APROD_W'(aging_rate) * APROD_W'(cur_attr.age);
    end
  end

  assign cur_eff = EFF_W'({cur_attr.prio, 16'h0000}) + EFF_W'(age_prod);

  assign sts.j_last   = (jcnt == cnt_m1);
  assign sts.i_last   = (icnt == cnt_m1);
  assign sts.out_free = !m_tvalid || m_tready;

  // Best per flavor; scan order is load order, so strict compares keep the earlier
  logic               best_a_vld, best_s_vld;
  logic [IDX_W-1:0]   best_a_idx, best_s_idx;
  logic [SEQ_W-1:0]   best_a_seq, best_s_seq;
  logic [EFF_W-1:0]   best_s_eff;
  logic               take;

  assign take = head && cur_attr.elig;

  always_ff @(posedge clk) begin
    if (cmd.pick_init) begin
      best_a_vld <= 1'b0;
      best_s_vld <= 1'b0;
    end else if (cmd.eval && take) begin
      if (!cur_attr.kind) begin
        if (!best_a_vld || cur_key.seq < best_a_seq) begin
          best_a_vld <= 1'b1;
          best_a_idx <= icnt[IDX_W-1:0];
          best_a_seq <= cur_key.seq;
        end
      end else begin
        if (!best_s_vld || cur_eff > best_s_eff ||
            (cur_eff == best_s_eff && cur_key.seq < best_s_seq)) begin
          best_s_vld <= 1'b1;
          best_s_idx <= icnt[IDX_W-1:0];
          best_s_seq <= cur_key.seq;
          best_s_eff <= cur_eff;
        end
      end
    end
  end

  // Result selection and output register
  logic             res_found, res_kind;
  logic [IDX_W-1:0] res_idx;
  logic [7:0]       res_idx_wide;

  always_comb begin
    res_found = 1'b0;
    res_kind  = 1'b0;
    res_idx   = '0;
    if (!cmd.out_none) begin
      if (primary_kind ? best_s_vld : best_a_vld) begin
        res_found = 1'b1;
        res_kind  = primary_kind;
        res_idx   = primary_kind ? best_s_idx : best_a_idx;
      end else if (primary_kind ? best_a_vld : best_s_vld) begin
        res_found = 1'b1;
        res_kind  = !primary_kind;
        res_idx   = primary_kind ? best_a_idx : best_s_idx;
      end
    end
  end

  assign res_idx_wide = 8'(res_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (cmd.out_load) begin
      m_tdata <= {1'b0, dropped, res_kind, res_idx_wide[CHOSEN_W-1:0], res_found};
    end
  end

endmodule

/* rtl/deficit_weighted_transfer_picker.sv */
// Top level of the deficit weighted transfer picker: config registers,
// sequencer and datapath. Depends on dwtp_pkg, dwtp_ctrl, dwtp_dp.
//
// Picks the next transfer among up to MAX_CANDIDATES (16) loaded candidates,
// favoring async or streaming traffic by a signed byte deficit. Requests come
// in on the s_ side, selected by s_tuser: a candidate request without s_tlast
// is stored and the next request is taken in the following cycle, as after a
// begin-window; window-submitted registers a 17x25 multiply, then does the
// add and clamp. The candidate with s_tlast set starts the pick, which steps
// over the store through one read port: for each stored candidate a read, a
// capture, a family-head compare against every stored candidate and an
// evaluate, then the result is loaded into the output register. An empty-list
// pick loads a result with nothing found. A result on m_ may sit waiting for
// m_tready while the next requests are taken; a new result waits only if the
// previous one has not left. Config writes are meant for idle periods.
// No clearing pass: the store is tracked by its fill count.
module deficit_weighted_transfer_picker (
  input  logic                             clk,
  input  logic                             rst,
  // request stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [0] is_eligible, [1] kind, [17:2] family_id, [49:18] submit_order,
  // [57:50] prio, [81:58] wait_age, [105:82] async_count,
  // [129:106] stream_count, [135:130] zero
  input  logic [dwtp_pkg::IN_DATA_W-1:0]   s_tdata,
  // [1:0] action
  input  logic [dwtp_pkg::USER_W-1:0]      s_tuser,
  input  logic                             s_tlast,
  // result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [0] found, [4:1] chosen_index, [5] chosen_kind, [6] overflow, [7] zero
  output logic [dwtp_pkg::OUT_DATA_W-1:0]  m_tdata,
  // config port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dwtp_pkg::ADDR_W-1:0]      paddr,
  input  logic [dwtp_pkg::PDATA_W-1:0]     pwdata,
  output logic [dwtp_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);
  import dwtp_pkg::*;

  logic [RATIO_W-1:0] stream_ratio;
  logic [AGING_W-1:0] aging_rate;
  logic [WSIZE_W-1:0] window_size;
  logic               cfg_wr;
  logic [1:0]         reg_idx;
  cmd_t               cmd;
  sts_t               sts;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_ratio <= RATIO_RESET;
      aging_rate   <= AGING_RESET;
      window_size  <= WSIZE_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_STREAM_RATIO: stream_ratio <= pwdata[RATIO_W-1:0];
        REG_AGING_RATE:   aging_rate   <= pwdata[AGING_W-1:0];
        REG_WINDOW_SIZE:  window_size  <= pwdata[WSIZE_W-1:0];
        default:          ;  // unmapped, ignored
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_STREAM_RATIO: prdata = PDATA_W'(stream_ratio);
      REG_AGING_RATE:   prdata = PDATA_W'(aging_rate);
      REG_WINDOW_SIZE:  prdata = PDATA_W'(window_size);
      default:          prdata = '0;
    endcase
  end

  dwtp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .sts      (sts),
    .cmd      (cmd)
  );

  dwtp_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_data      (s_tdata),
    .stream_ratio (stream_ratio),
    .aging_rate   (aging_rate),
    .window_size  (window_size),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata)
  );

endmodule

/* rtl/dwtp_checker.sv */
// Port-level checker for the picker, bound to the top level.
// Depends on dwtp_pkg and deficit_weighted_transfer_picker_defines.svh.
`include "deficit_weighted_transfer_picker_defines.svh"

module dwtp_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic [dwtp_pkg::USER_W-1:0]      s_tuser,
  input logic                             s_tlast,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [dwtp_pkg::OUT_DATA_W-1:0]  m_tdata
);
  import dwtp_pkg::*;

  logic acc;
  assign acc = s_tvalid && s_tready;

  // stalled result holds
  `DWTP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")

  // no chosen candidate means index and kind are zero
  `DWTP_ASSERT_NOW(a_none_zero, m_tvalid && !m_tdata[0], m_tdata[5:1] == 5'd0, "empty result carries index or kind")

  // submit, empty pick and the last candidate keep the block busy next cycle
  `DWTP_ASSERT_NEXT(a_busy_after, acc && (s_tuser == ACT_SUBMIT || s_tuser == ACT_EMPTY || (s_tuser == ACT_CAND && s_tlast)), !s_tready, "request taken while still busy")

  // plain candidate and begin-window leave the block ready in the next cycle
  `DWTP_ASSERT_NEXT(a_quick, acc && (s_tuser == ACT_BEGIN || (s_tuser == ACT_CAND && !s_tlast)), s_tready, "single-cycle request stalled")

endmodule

bind deficit_weighted_transfer_picker dwtp_checker u_dwtp_checker (.*);

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for deficit_weighted_transfer_picker: directed table, then
// random request lists under several register settings, each pick checked on the fly.
// Depends on dwtp_pkg and the picker RTL only.
module testbench;
  import dwtp_pkg::*;

  localparam int PICK_SETTLE  = 400;    // settle time after the last pick, covers a full-store pick
  localparam int STALL_LIMIT  = 20000;  // cycles with no handshake before giving up
  localparam int HOLD_CYCLES  = 2500;   // long result back-pressure, once
  localparam int RANDOM_ITEMS = 1950;
  localparam int PHASES       = 6;      // phase 0 runs on reset values

  typedef struct packed {
    action_t     act;
    logic        elig;
    logic        kind;
    logic [15:0] family;
    logic [31:0] seq;
    logic [7:0]  prio;
    logic [23:0] age;
    logic        last;
    logic [23:0] async_len;
    logic [23:0] stream_len;
  } request_t;

  typedef struct packed {
    logic       found;
    logic [3:0] index;
    logic       kind;
    logic       overflow;
  } pick_t;

  typedef struct packed {
    request_t req;
    logic     typed;   // pick below is the expectation, else the predictor decides
    pick_t    pick;
  } directed_row_t;

  localparam pick_t NO_PICK = '0;

  // pick columns: found, index, kind, overflow
  localparam int DIRECTED_ROWS = 22;
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    // empty-list pick straight after reset
    '{'{ACT_EMPTY, 1'b0, 1'b0, 16'd0, 32'd0, 8'd0, 24'd0, 1'b0, 24'd0, 24'd0},
      1'b1, NO_PICK},
    // lone eligible async candidate
    '{'{ACT_CAND, 1'b1, 1'b0, 16'd0, 32'd0, 8'd0, 24'd0, 1'b1, 24'd0, 24'd0},
      1'b1, '{1'b1, 4'd0, 1'b0, 1'b0}},
    // lone ineligible candidate, every field at its top value
    '{'{ACT_CAND, 1'b0, 1'b1, 16'hFFFF, 32'hFFFFFFFF, 8'hFF, 24'hFFFFFF, 1'b1,
        24'hFFFFFF, 24'hFFFFFF}, 1'b1, NO_PICK},
    // ineligible head blocks family 5, so family 7 wins
    '{'{ACT_CAND, 1'b0, 1'b0, 16'd5, 32'd10, 8'd0, 24'd0, 1'b0, 24'd0, 24'd0},
      1'b0, NO_PICK},
    '{'{ACT_CAND, 1'b1, 1'b0, 16'd5, 32'd20, 8'd0, 24'd0, 1'b0, 24'd0, 24'd0},
      1'b0, NO_PICK},
    '{'{ACT_CAND, 1'b1, 1'b0, 16'd7, 32'd30, 8'd0, 24'd0, 1'b1, 24'd0, 24'd0},
      1'b1, '{1'b1, 4'd2, 1'b0, 1'b0}},
    // async primary beats a top-priority streaming candidate
    '{'{ACT_CAND, 1'b1, 1'b1, 16'd1, 32'd1, 8'hFF, 24'hFFFFFF, 1'b0, 24'd0, 24'd0},
      1'b0, NO_PICK},
    '{'{ACT_CAND, 1'b1, 1'b0, 16'd2, 32'd9, 8'd0, 24'd0, 1'b1, 24'd0, 24'd0},
      1'b0, NO_PICK},
    // async-only window: deficit clamps at +window, next window favors streaming
    '{'{ACT_SUBMIT, 1'b0, 1'b0, 16'd0, 32'd0, 8'd0, 24'd0, 1'b0, 24'hFFFFFF, 24'd0},
      1'b0, NO_PICK},
    '{'{ACT_BEGIN, 1'b0, 1'b0, 16'd0, 32'd0, 8'd0, 24'd0, 1'b0, 24'd0, 24'd0},
      1'b0, NO_PICK},
    // equal effective priority: lower sequence wins
    '{'{ACT_CAND, 1'b1, 1'b1, 16'd1, 32'd5, 8'd10, 24'd0, 1'b0, 24'd0, 24'd0},
      1'b0, NO_PICK},
    '{'{ACT_CAND, 1'b1, 1'b1, 16'd2, 32'd3, 8'd10, 24'd0, 1'b0, 24'd0, 24'd0},
      1'b0, NO_PICK},
    '{'{ACT_CAND, 1'b1, 1'b0, 16'd3, 32'd0, 8'd0, 24'd0, 1'b1, 24'd0, 24'd0},
      1'b0, NO_PICK},
    // fully equal streaming keys: earlier load wins
    '{'{ACT_CAND, 1'b1, 1'b1, 16'd8, 32'd7, 8'd3, 24'd0, 1'b0, 24'd0, 24'd0},
      1'b0, NO_PICK},
    '{'{ACT_CAND, 1'b1, 1'b1, 16'd9, 32'd7, 8'd3, 24'd0, 1'b1, 24'd0, 24'd0},
      1'b0, NO_PICK},
    // streaming-only window: deficit clamps at -window, back to async
    '{'{ACT_SUBMIT, 1'b0, 1'b0, 16'd0, 32'd0, 8'd0, 24'd0, 1'b0, 24'd0, 24'hFFFFFF},
      1'b0, NO_PICK},
    '{'{ACT_BEGIN, 1'b0, 1'b0, 16'd0, 32'd0, 8'd0, 24'd0, 1'b0, 24'd0, 24'd0},
      1'b0, NO_PICK},
    // equal async sequences
    '{'{ACT_CAND, 1'b1, 1'b0, 16'd1, 32'd4, 8'd0, 24'd0, 1'b0, 24'd0, 24'd0},
      1'b0, NO_PICK},
    '{'{ACT_CAND, 1'b1, 1'b0, 16'd2, 32'd4, 8'd0, 24'd0, 1'b1, 24'd0, 24'd0},
      1'b0, NO_PICK},
    // partly loaded list thrown away by an empty-list pick
    '{'{ACT_CAND, 1'b1, 1'b0, 16'd0, 32'd0, 8'd0, 24'd0, 1'b0, 24'd0, 24'd0},
      1'b0, NO_PICK},
    '{'{ACT_EMPTY, 1'b0, 1'b0, 16'd0, 32'd0, 8'd0, 24'd0, 1'b0, 24'd0, 24'd0},
      1'b1, NO_PICK},
    // nothing of the primary (async) flavor: falls back to streaming
    '{'{ACT_CAND, 1'b1, 1'b1, 16'd3, 32'd1, 8'd0, 24'd0, 1'b1, 24'd0, 24'd0},
      1'b1, '{1'b1, 4'd0, 1'b1, 1'b0}}
  };

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic [USER_W-1:0]     s_tuser  = '0;
  logic                  s_tlast  = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [ADDR_W-1:0]     paddr    = '0;
  logic [PDATA_W-1:0]    pwdata   = '0;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;

  deficit_weighted_transfer_picker dut (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: own copy of the registers, deficit, flavor and candidate store
  // ---------------------------------------------------------------------------
  logic [16:0] ratio_cfg  = RATIO_RESET;
  logic [15:0] aging_cfg  = AGING_RESET;
  logic [23:0] window_cfg = WSIZE_RESET;
  longint      deficit_q  = 0;
  logic        primary_q  = 1'b0;   // 0 async, 1 streaming
  request_t    held [MAX_CANDIDATES];
  int          held_count = 0;
  logic        dropped_q  = 1'b0;

  pick_t pending_picks [$];   // picks predicted but not yet seen on m_
  int    errors        = 0;
  int    picks_checked = 0;
  bit    send_idle     = 1'b1;
  bit    recv_idle     = 1'b1;
  bit    hold_done     = 1'b0;

  // A head has no stored sibling with a smaller sequence.
  function automatic bit heads_family(input int i);
    for (int j = 0; j < held_count; j++)
      if (j != i && held[j].family == held[i].family && held[j].seq < held[i].seq)
        return 1'b0;
    return 1'b1;
  endfunction

  // Best candidate of one flavor, -1 if none qualifies. Strict compares keep
  // the earlier load on a full tie.
  function automatic int best_of_flavor(input logic flav);
    int          best;
    logic [63:0] best_eff;
    logic [63:0] eff;
    best     = -1;
    best_eff = '0;
    for (int i = 0; i < held_count; i++) begin
      if (held[i].elig && held[i].kind == flav && heads_family(i)) begin
        // Q.16 effective priority: prio * 65536 + Q8.8 rate * age (1/256 s)
        eff = (64'(held[i].prio) << 16) + 64'(aging_cfg) * 64'(held[i].age);
        if (flav == 1'b0) begin
          if (best < 0 || held[i].seq < held[best].seq)
            best = i;
        end else if (best < 0 || eff > best_eff ||
                     (eff == best_eff && held[i].seq < held[best].seq)) begin
          best     = i;
          best_eff = eff;
        end
      end
    end
    return best;
  endfunction

  function automatic void predict_request(input request_t r, output bit has_pick,
                                          output pick_t p);
    longint ratio;
    longint total;
    longint next;
    longint hi;
    longint lo;
    int     best;
    has_pick = 1'b0;
    p        = NO_PICK;
    case (r.act)
      ACT_BEGIN: primary_q = (deficit_q > 0);
      ACT_SUBMIT: begin
        // ratio above one saturates; window zero falls back to the 26-bit range
        ratio = (ratio_cfg > 17'd65536) ? 65536 : longint'(ratio_cfg);
        total = longint'(r.async_len) + longint'(r.stream_len);
        next  = deficit_q + ((ratio * total) >> 16) - longint'(r.stream_len);
        hi    = (window_cfg != 0) ? longint'(window_cfg) : 33554431;
        lo    = (window_cfg != 0) ? -longint'(window_cfg) : -33554432;
        if (next > hi) next = hi;
        if (next < lo) next = lo;
        deficit_q = next;
      end
      ACT_EMPTY: begin
        has_pick   = 1'b1;
        p.overflow = dropped_q;
        held_count = 0;
        dropped_q  = 1'b0;
      end
      default: begin
        if (held_count < MAX_CANDIDATES) begin
          held[held_count] = r;
          held_count++;
        end else begin
          dropped_q = 1'b1;   // store full: request dropped, pick still runs
        end
        if (r.last) begin
          best = best_of_flavor(primary_q);
          if (best < 0)
            best = best_of_flavor(~primary_q);
          has_pick = 1'b1;
          if (best >= 0) begin
            p.found = 1'b1;
            p.index = best[3:0];
            p.kind  = held[best].kind;
          end
          p.overflow = dropped_q;
          held_count = 0;
          dropped_q  = 1'b0;
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Entered and left at a falling edge; a zero gap keeps s_tvalid high.
  task automatic send_request(input request_t r, input bit typed, input pick_t typed_pick);
    int    gap;
    bit    has_pick;
    pick_t p;
    gap = send_idle ? $urandom_range(19, 0) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tuser  <= r.act;
    s_tlast  <= r.last;
    s_tdata  <= {6'b0, r.stream_len, r.async_len, r.age, r.prio, r.seq,
                 r.family, r.kind, r.elig};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    predict_request(r, has_pick, p);
    if (has_pick)
      pending_picks.push_back(typed ? typed_pick : p);
    @(negedge clk);
  endtask

  function automatic request_t random_fields();
    request_t r;
    r.act        = action_t'($urandom_range(3, 0));
    r.elig       = $urandom_range(4, 0) != 0;
    r.kind       = $urandom_range(1, 0);
    r.family     = $urandom_range(16'hFFFF, 0);
    r.seq        = $urandom();
    r.prio       = $urandom_range(8'hFF, 0);
    r.age        = $urandom_range(24'hFFFFFF, 0);
    r.last       = $urandom_range(1, 0);
    r.async_len  = $urandom_range(1, 0) ? $urandom_range(24'hFFFFFF, 0)
                                        : $urandom_range(4095, 0);
    r.stream_len = $urandom_range(1, 0) ? $urandom_range(24'hFFFFFF, 0)
                                        : $urandom_range(4095, 0);
    return r;
  endfunction

  // Mostly well-formed candidate lists with random content; some lists are
  // left open so the next one piles on top, now and then past the store size.
  task automatic run_random(input int quota);
    int       sent;
    int       len;
    int       roll;
    bit       open_end;
    bit       narrow_fam;
    bit       narrow_seq;
    bit       narrow_prio;
    bit       narrow_age;
    request_t r;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(9, 0) == 0)
        send_idle = $urandom_range(3, 0) != 0;
      roll = $urandom_range(99, 0);
      if (roll < 30) begin
        r = random_fields();
        r.act = (roll < 12) ? ACT_BEGIN : (roll < 26) ? ACT_SUBMIT : ACT_EMPTY;
        send_request(r, 1'b0, NO_PICK);
        sent++;
      end else begin
        roll = $urandom_range(99, 0);
        len  = (roll < 80) ? $urandom_range(8, 1) :
               (roll < 94) ? $urandom_range(16, 9) : $urandom_range(20, 17);
        open_end    = $urandom_range(9, 0) == 0;
        narrow_fam  = $urandom_range(1, 0);
        narrow_seq  = $urandom_range(1, 0);
        narrow_prio = $urandom_range(1, 0);
        narrow_age  = $urandom_range(1, 0);
        for (int k = 0; k < len; k++) begin
          r = random_fields();
          r.act = ACT_CAND;
          if (narrow_fam)  r.family = $urandom_range(3, 0);
          if (narrow_seq)  r.seq    = $urandom_range(7, 0);
          if (narrow_prio) r.prio   = $urandom_range(3, 0);
          if (narrow_age)  r.age    = $urandom_range(3, 0);
          r.last = (k == len - 1) && !open_end;
          send_request(r, 1'b0, NO_PICK);
          sent++;
        end
      end
    end
  endtask

  // Drop s_tvalid, drain all predicted picks, then let any trailing
  // non-result request finish inside the block.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_picks.size() != 0) @(negedge clk);
    repeat (PICK_SETTLE) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Config port
  // ---------------------------------------------------------------------------
  task automatic apb_access(input logic [1:0] idx, input bit wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_register(input logic [1:0] idx);
    logic [31:0] want;
    logic [31:0] got;
    case (idx)
      REG_STREAM_RATIO: want = 32'(ratio_cfg);
      REG_AGING_RATE:   want = 32'(aging_cfg);
      default:          want = 32'(window_cfg);
    endcase
    apb_access(idx, 1'b0, '0, got);
    if (got !== want) begin
      $error("register %0d: expected %h, got %h", idx, want, got);
      errors++;
    end
  endtask

  task automatic set_register(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] unused;
    apb_access(idx, 1'b1, value, unused);
    case (idx)
      REG_STREAM_RATIO: ratio_cfg  = value[16:0];
      REG_AGING_RATE:   aging_cfg  = value[15:0];
      default:          window_cfg = value[23:0];
    endcase
    check_register(idx);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, plus one long hold-off that backs the block
  // up into its request port.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(15, 0) == 0)
        recv_idle = $urandom_range(3, 0) != 0;
      stall = recv_idle ? $urandom_range(19, 0) : 0;
      if (!hold_done && picks_checked >= 30) begin
        stall     = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  function automatic void check_field(input string name, input logic [3:0] want,
                                      input logic [3:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    pick_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_picks.size() == 0) begin
        $error("pick result %h with no request outstanding", m_tdata);
        errors++;
      end else begin
        want = pending_picks.pop_front();
        // m_tdata: [0] found, [4:1] chosen_index, [5] chosen_kind, [6] overflow
        check_field("found", 4'(want.found), 4'(m_tdata[0]));
        check_field("chosen_index", want.index, m_tdata[4:1]);
        check_field("chosen_kind", 4'(want.kind), 4'(m_tdata[5]));
        check_field("overflow", 4'(want.overflow), 4'(m_tdata[6]));
      end
      picks_checked++;
    end
  end

  // Watchdog: any handshake on either stream or the config port resets it.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // registers come out of reset at their documented values
    check_register(REG_STREAM_RATIO);
    check_register(REG_AGING_RATE);
    check_register(REG_WINDOW_SIZE);

    send_idle = 1'b1;
    for (int k = 0; k < DIRECTED_ROWS; k++)
      send_request(DIRECTED[k].req, DIRECTED[k].typed, DIRECTED[k].pick);

    for (int ph = 1; ph < PHASES; ph++) begin
      settle();
      case (ph)
        1: begin   // no streaming share, steepest aging, tightest window
          set_register(REG_STREAM_RATIO, 32'd0);
          set_register(REG_AGING_RATE, 32'hFFFF);
          set_register(REG_WINDOW_SIZE, 32'd1);
        end
        2: begin   // full streaming share, no aging, widest window
          set_register(REG_STREAM_RATIO, 32'd65536);
          set_register(REG_AGING_RATE, 32'd0);
          set_register(REG_WINDOW_SIZE, 32'hFFFFFF);
        end
        3: begin   // ratio above one, window zero (26-bit clamp)
          set_register(REG_STREAM_RATIO, 32'h1FFFF);
          set_register(REG_AGING_RATE, 32'h0100);
          set_register(REG_WINDOW_SIZE, 32'd0);
        end
        default: begin
          set_register(REG_STREAM_RATIO, $urandom_range(17'h1FFFF, 0));
          set_register(REG_AGING_RATE, $urandom_range(16'hFFFF, 0));
          set_register(REG_WINDOW_SIZE, $urandom_range(24'hFFFFFF, 0));
        end
      endcase
      run_random(RANDOM_ITEMS / (PHASES - 1));
    end

    settle();
    if (errors == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule
